/* src/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, constants and elaboration-time helpers for the pendulum core.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

  localparam int unsigned DEF_WORD_BITS       = 32;
  localparam int unsigned DEF_TRIG_ITERATIONS = 24;

  // pi in Q4.60 and the Q3.28 angle constants derived from it
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI28_W    = (PI_Q60 + (64'd1 << 31)) >> 32;
  localparam logic [63:0] HALF28_W  = (PI_Q60 + (64'd1 << 32)) >> 33;
  localparam logic [63:0] TWOPI28_W = (PI_Q60 + (64'd1 << 30)) >> 31;
  localparam logic signed [31:0] PI28     = PI28_W[31:0];
  localparam logic signed [31:0] HALF28   = HALF28_W[31:0];
  localparam logic signed [31:0] TWO_PI28 = TWOPI28_W[31:0];

  localparam logic [63:0] GAIN_NUM = 64'd607252935008881256;
  localparam logic [63:0] GAIN_DEN = 64'd1000000000000000000;

  localparam logic [31:0] GRAVITY_RESET = 32'd642908;
  localparam logic [31:0] LENGTH_RESET  = 32'd65536;

  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAVITY = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH  = 8'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] start_angle;
    logic [23:0]        time_step;
  } pes_in_t;

  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] bob_x;
    logic signed [31:0] bob_y;
  } pes_out_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } pes_trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin;
    logic signed [31:0] cos;
  } pes_trig_rsp_t;

  // restoring division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q4.60 by its series
  function automatic logic [63:0] atan_q60(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    int          e;
    sum  = '0;
    stop = 1'b0;
    if (i == 0) begin
      sum = PI_Q60 >> 2;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - int'(i) * (2 * k + 1);
        if (!stop) begin
          if (e < 0) begin
            stop = 1'b1;
          end else begin
            term = udiv64(64'd1 << e, 64'(2 * k + 1));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

  // CORDIC gain prescale rounded to frac fraction bits
  function automatic logic [63:0] gain_q(input int unsigned frac);
    logic [63:0] r;
    logic [63:0] q;
    r = GAIN_NUM;
    q = '0;
    for (int k = 0; k <= int'(frac); k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= GAIN_DEN) begin
        q[0] = 1'b1;
        r    = r - GAIN_DEN;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

endpackage

`default_nettype wire

/* src/pes_mul.sv */
// ----------------------------------------------------------------------------
// pes_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_mul import pes_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* src/pes_cordic.sv */
// ----------------------------------------------------------------------------
// pes_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_cordic import pes_pkg::*; #(
  parameter int unsigned WORD_BITS       = DEF_WORD_BITS,
  parameter int unsigned TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pes_trig_req_t req_i,
  output pes_trig_rsp_t      rsp_o
);

  localparam int unsigned FRAC   = WORD_BITS - 2;
  localparam int unsigned SHR    = 60 - FRAC;
  localparam int unsigned ITER_W = $clog2(TRIG_ITERATIONS);
  localparam int unsigned RW     = WORD_BITS + 8;
  localparam logic [ITER_W-1:0] LAST = ITER_W'(TRIG_ITERATIONS - 1);
  localparam logic [63:0] GAIN_W = gain_q(FRAC);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } cstate_e;

  cstate_e                     state_q, state_d;
  logic [ITER_W-1:0]           idx_q, idx_d;
  logic signed [WORD_BITS-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic                        flip_q, flip_d;
  logic                        done_q, done_d;
  logic signed [31:0]          sin_q, sin_d, cos_q, cos_d;

  logic signed [WORD_BITS-1:0] atan_rom [TRIG_ITERATIONS];

  for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_rom
    localparam logic [63:0] ROUNDED = (atan_q60(g) + (64'd1 << (SHR - 1))) >> SHR;
    assign atan_rom[g] = ROUNDED[WORD_BITS-1:0];
  end

  // fold into [-pi/2, pi/2]
  logic signed [32:0] a_ext, a_adj;
  logic               a_flip;
  always_comb begin
    a_ext  = 33'(req_i.angle);
    a_flip = 1'b0;
    a_adj  = a_ext;
    if (a_ext > 33'(HALF28)) begin
      a_adj  = a_ext - 33'(PI28);
      a_flip = 1'b1;
    end else if (a_ext < -33'(HALF28)) begin
      a_adj  = a_ext + 33'(PI28);
      a_flip = 1'b1;
    end
  end

  logic signed [WORD_BITS-1:0] z_init;
  if (FRAC >= 28) begin : g_z_up
    assign z_init = WORD_BITS'(a_adj) <<< (FRAC - 28);
  end else begin : g_z_dn
    logic [32:0] zm;
    logic [32:0] zr;
    assign zm     = a_adj[32] ? -a_adj : a_adj;
    assign zr     = (zm + (33'd1 << (27 - FRAC))) >> (28 - FRAC);
    assign z_init = a_adj[32] ? -WORD_BITS'(zr) : WORD_BITS'(zr);
  end

  // rescale to Q2.30 and clamp to the unit range
  logic signed [RW-1:0] xr, yr;
  if (FRAC > 30) begin : g_o_dn
    logic [RW-1:0] xm, ym, xrm, yrm;
    assign xm  = x_q[WORD_BITS-1] ? -RW'(x_q) : RW'(x_q);
    assign ym  = y_q[WORD_BITS-1] ? -RW'(y_q) : RW'(y_q);
    assign xrm = (xm + (RW'(1) << (FRAC - 31))) >> (FRAC - 30);
    assign yrm = (ym + (RW'(1) << (FRAC - 31))) >> (FRAC - 30);
    assign xr  = x_q[WORD_BITS-1] ? -xrm : xrm;
    assign yr  = y_q[WORD_BITS-1] ? -yrm : yrm;
  end else begin : g_o_up
    assign xr = RW'(x_q) <<< (30 - FRAC);
    assign yr = RW'(y_q) <<< (30 - FRAC);
  end

  function automatic logic signed [31:0] clamp_unit(input logic signed [RW-1:0] v);
    if (v > (RW'(1) <<< 30)) return 32'sd1073741824;
    if (v < -(RW'(1) <<< 30)) return -32'sd1073741824;
    return v[31:0];
  endfunction

  logic signed [31:0] xc, yc;
  logic signed [WORD_BITS-1:0] xs, ys;
  assign xc = clamp_unit(xr);
  assign yc = clamp_unit(yr);
  assign xs = x_q >>> idx_q;
  assign ys = y_q >>> idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    flip_d  = flip_q;
    done_d  = 1'b0;
    sin_d   = sin_q;
    cos_d   = cos_q;
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          x_d     = GAIN_W[WORD_BITS-1:0];
          y_d     = '0;
          z_d     = z_init;
          flip_d  = a_flip;
          idx_d   = '0;
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        if (!z_q[WORD_BITS-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_rom[idx_q];
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_rom[idx_q];
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = C_FIN;
        end
      end
      C_FIN: begin
        sin_d   = flip_q ? -yc : yc;
        cos_d   = flip_q ? -xc : xc;
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sin  = sin_q;
  assign rsp_o.cos  = cos_q;

endmodule

`default_nettype wire

/* src/pendulum_euler_step_core.sv */
// ----------------------------------------------------------------------------
// pendulum_euler_step_core
// Simple pendulum advanced by semi-implicit Euler steps in fixed point.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | pes_in_t: command, angle, dt
//   out     | output    | out_valid_o/out_ready_i| pes_out_t: angle, bob x, y
//   cfg     | input     | cfg_valid_i/cfg_ready_o| index + 32-bit data
//
// A new start or step word is accepted only once the previous one has been
// handed to the output register; the CORDIC loop dominates the run time, one
// micro-rotation a cycle, with the 33x33 multiplier and a six-step modulo
// reduction shared in sequence. in_ready_o is high only while idle.
// Reset clears state, angle, speed and the output valid and loads the gravity and length defaults; no clearing pass.
// A finished word waits in the output register while the next input runs;
// a second finished word holds until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module pendulum_euler_step_core import pes_pkg::*; #(
  parameter int unsigned WORD_BITS       = DEF_WORD_BITS,
  parameter int unsigned TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire pes_in_t                   in_word_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output pes_out_t                       out_word_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [31:0]               cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIG1,
    S_GMUL,
    S_ACC,
    S_HI,
    S_LO,
    S_SPD,
    S_VMUL,
    S_VEL,
    S_WRAP,
    S_MOD,
    S_TRIG2,
    S_XMUL,
    S_YMUL,
    S_YSET,
    S_OUT
  } state_e;

  // reduction accumulator width: covers angle + speed*dt + pi
  localparam int unsigned RB = 38;
  localparam logic signed [RB-1:0] PI_R    = RB'(PI28);
  localparam logic signed [RB-1:0] TWOPI_R = RB'(TWO_PI28);

  state_e             state_q, state_d;
  logic [31:0]        grav_q, len_q;
  logic signed [31:0] swing_q, swing_d;
  logic signed [31:0] speed_q, speed_d;
  logic [23:0]        dt_q, dt_d;
  logic [40:0]        acc_mag_q, acc_mag_d;
  logic               acc_neg_q, acc_neg_d;
  logic [65:0]        part_q, part_d;
  logic signed [RB-1:0] r_q, r_d;
  logic [2:0]         k_q, k_d;
  logic signed [31:0] bx_q, bx_d, by_q, by_d;
  logic               out_valid_q, out_valid_d;
  pes_out_t           out_q, out_d;

  pes_trig_req_t      trig_req;
  pes_trig_rsp_t      trig_rsp;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  pes_cordic #(
    .WORD_BITS       (WORD_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .rsp_o  (trig_rsp)
  );

  pes_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // round-half-away magnitude of a signed product after a right shift
  function automatic logic [65:0] rnd_mag(input logic signed [65:0] v, input int unsigned s);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    return (m + (66'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -43'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic                 in_fire;
  logic [65:0]          pm;
  logic [65:0]          mag_sum;
  logic [41:0]          dv_mag;
  logic signed [42:0]   spd_sum;
  logic signed [RB-1:0] v_step;
  logic signed [RB-1:0] mod_step;
  logic signed [RB-1:0] r_next;
  logic signed [31:0]   angle_new;
  logic signed [42:0]   pos_val;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    // shared datapath terms
    pm        = rnd_mag(mul_p, 22);
    mag_sum   = (part_q << 20) + 66'(mul_p);
    dv_mag    = 42'((mag_sum + (66'd1 << 23)) >> 24);
    spd_sum   = acc_neg_q ? 43'(speed_q) - 43'(dv_mag) : 43'(speed_q) + 43'(dv_mag);
    v_step    = mul_p[65] ? -RB'(rnd_mag(mul_p, 20)) : RB'(rnd_mag(mul_p, 20));
    mod_step  = TWOPI_R <<< k_q;
    r_next    = (r_q >= mod_step) ? r_q - mod_step : r_q;
    angle_new = 32'(r_next - PI_R);
    pos_val   = 43'(rnd_mag(mul_p, 30));

    state_d     = state_q;
    swing_d     = swing_q;
    speed_d     = speed_q;
    dt_d        = dt_q;
    acc_mag_d   = acc_mag_q;
    acc_neg_d   = acc_neg_q;
    part_d      = part_q;
    r_d         = r_q;
    k_d         = k_q;
    bx_d        = bx_q;
    by_d        = by_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    trig_req.start = 1'b0;
    trig_req.angle = swing_q;
    mul_a          = '0;
    mul_b          = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          dt_d = in_word_i.time_step;
          if (in_word_i.command == CMD_START) begin
            // load angle, clear speed, then reduce
            speed_d = '0;
            r_d     = RB'(in_word_i.start_angle) + PI_R;
            state_d = S_WRAP;
          end else begin
            trig_req.start = 1'b1;
            state_d        = S_TRIG1;
          end
        end
      end
      S_TRIG1: begin
        if (trig_rsp.done) begin
          state_d = S_GMUL;
        end
      end
      S_GMUL: begin
        mul_a   = {1'b0, grav_q};
        mul_b   = 33'(trig_rsp.sin);
        state_d = S_ACC;
      end
      S_ACC: begin
        // acceleration is minus the rounded product
        acc_mag_d = pm[40:0];
        acc_neg_d = !mul_p[65];
        state_d   = S_HI;
      end
      S_HI: begin
        mul_a   = 33'(acc_mag_q[40:20]);
        mul_b   = 33'(dt_q);
        state_d = S_LO;
      end
      S_LO: begin
        part_d  = 66'(mul_p);
        mul_a   = 33'(acc_mag_q[19:0]);
        mul_b   = 33'(dt_q);
        state_d = S_SPD;
      end
      S_SPD: begin
        speed_d = sat32(spd_sum);
        state_d = S_VMUL;
      end
      S_VMUL: begin
        mul_a   = 33'(speed_q);
        mul_b   = 33'(dt_q);
        state_d = S_VEL;
      end
      S_VEL: begin
        r_d     = RB'(swing_q) + v_step + PI_R;
        state_d = S_WRAP;
      end
      S_WRAP: begin
        // one lift makes the value nonnegative for the range seen here
        if (r_q[RB-1]) begin
          r_d = r_q + (TWOPI_R <<< 5);
        end
        k_d     = 3'd5;
        state_d = S_MOD;
      end
      S_MOD: begin
        r_d = r_next;
        k_d = k_q - 3'd1;
        if (k_q == 3'd0) begin
          swing_d        = angle_new;
          trig_req.start = 1'b1;
          trig_req.angle = angle_new;
          state_d        = S_TRIG2;
        end
      end
      S_TRIG2: begin
        if (trig_rsp.done) begin
          state_d = S_XMUL;
        end
      end
      S_XMUL: begin
        mul_a   = {1'b0, len_q};
        mul_b   = 33'(trig_rsp.sin);
        state_d = S_YMUL;
      end
      S_YMUL: begin
        bx_d    = sat32(mul_p[65] ? -pos_val : pos_val);
        mul_a   = {1'b0, len_q};
        mul_b   = 33'(trig_rsp.cos);
        state_d = S_YSET;
      end
      S_YSET: begin
        by_d    = sat32(mul_p[65] ? pos_val : -pos_val);
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.angle_out = swing_q;
          out_d.bob_x     = bx_q;
          out_d.bob_y     = by_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      swing_q     <= '0;
      speed_q     <= '0;
      grav_q      <= GRAVITY_RESET;
      len_q       <= LENGTH_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      swing_q     <= swing_d;
      speed_q     <= speed_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GRAVITY: grav_q <= cfg_data_i;
          CFG_LENGTH:  len_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q      <= dt_d;
    acc_mag_q <= acc_mag_d;
    acc_neg_q <= acc_neg_d;
    part_q    <= part_d;
    r_q       <= r_d;
    k_q       <= k_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
